### hw/rtl/ascii_range_frame_parser_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ASCII range frame parser
// Clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASCII_RANGE_FRAME_PARSER_TOP_ASSERT_SVH
`define ASCII_RANGE_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication
`define ARFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication
`define ARFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

### hw/rtl/arfp_pkg.sv
// ---------------------------------------------------------------------------
// arfp_pkg
// Types and constants shared by the ASCII range frame parser.
// ---------------------------------------------------------------------------
package arfp_pkg;

  localparam int unsigned ValueW   = 14;
  localparam int unsigned DigitsW  = 3;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned TimeoutW = 10;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Characters
  localparam logic [7:0] CH_START = 8'h52;  // 'R'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 10'd500;
  localparam logic [DigitsW-1:0]  COUNT_MAX     = 3'd5;
  localparam logic [DigitsW-1:0]  COUNT_VALUE   = 3'd4;  // digits taken into the value
  localparam logic [DigitsW-1:0]  COUNT_MIN_OK  = 3'd3;
  localparam logic [ElapsedW-1:0] ELAPSED_MAX   = 10'd1023;

  typedef struct packed {
    logic                in_frame;
    logic [DigitsW-1:0]  digit_count;
    logic [ValueW-1:0]   value_accum;
    logic [ElapsedW-1:0] elapsed_ms;
  } arfp_state_t;

  typedef struct packed {
    logic [ValueW-1:0]  range_value;
    logic [DigitsW-1:0] digit_total;
  } arfp_result_t;

endpackage

### hw/rtl/arfp_item_if.sv
// ---------------------------------------------------------------------------
// arfp_item_if
// Input channel: received byte or millisecond tick.
// ---------------------------------------------------------------------------
interface arfp_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

### hw/rtl/arfp_result_if.sv
// ---------------------------------------------------------------------------
// arfp_result_if
// Output channel: one completed range frame.
// ---------------------------------------------------------------------------
interface arfp_result_if;
  logic        valid;
  logic        ready;
  logic [13:0] range_value;
  logic [2:0]  digit_total;

  modport source (output valid, output range_value, output digit_total, input ready);
  modport sink   (input valid, input range_value, input digit_total, output ready);
endinterface

### hw/rtl/arfp_cfg_if.sv
// ---------------------------------------------------------------------------
// arfp_cfg_if
// Configuration write channel for the timeout register.
// ---------------------------------------------------------------------------
interface arfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] timeout_ms;

  modport source (output valid, output timeout_ms, input ready);
  modport sink   (input valid, input timeout_ms, output ready);
endinterface

### hw/rtl/arfp_step.sv
// ---------------------------------------------------------------------------
// arfp_step
// Next-state and result logic for one byte or tick.
// ---------------------------------------------------------------------------
module arfp_step (
  input  arfp_pkg::arfp_state_t  state_i,
  input  logic [9:0]             timeout_ms_i,
  input  logic                   kind_i,
  input  logic [7:0]             rx_byte_i,
  output arfp_pkg::arfp_state_t  state_o,
  output logic                   emit_o,
  output arfp_pkg::arfp_result_t result_o
);
  import arfp_pkg::*;

  logic              is_digit;
  logic [3:0]        digit_val;
  logic [ValueW-1:0] value_x10;

  assign is_digit  = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
  assign digit_val = rx_byte_i[3:0];  // low nibble of '0'..'9'
  // value * 10 as (value << 3) + (value << 1), kept to 14 bits
  assign value_x10 = {state_i.value_accum[ValueW-4:0], 3'b000}
                   + {state_i.value_accum[ValueW-2:0], 1'b0};

  assign result_o.range_value = state_i.value_accum;
  assign result_o.digit_total = state_i.digit_count;

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    if (kind_i == KIND_TICK) begin
      // elapsed time runs only inside a frame
      if (state_i.in_frame && (state_i.elapsed_ms != ELAPSED_MAX)) begin
        state_o.elapsed_ms = state_i.elapsed_ms + 10'd1;
      end
    end else if (rx_byte_i == CH_START) begin
      state_o.in_frame    = 1'b1;
      state_o.elapsed_ms  = '0;
      state_o.digit_count = '0;
      state_o.value_accum = '0;
    end else if (!state_i.in_frame) begin
      // stray byte, ignored
    end else if (state_i.elapsed_ms > timeout_ms_i) begin
      // late byte drops the frame
      state_o.in_frame    = 1'b0;
      state_o.digit_count = '0;
      state_o.value_accum = '0;
    end else if (rx_byte_i == CH_CR) begin
      emit_o = (state_i.digit_count == COUNT_MIN_OK) ||
               (state_i.digit_count == COUNT_VALUE);
      state_o.in_frame    = 1'b0;
      state_o.digit_count = '0;
      state_o.value_accum = '0;
    end else if (is_digit) begin
      if (state_i.digit_count < COUNT_VALUE) begin
        state_o.value_accum = value_x10 + {{(ValueW-4){1'b0}}, digit_val};
      end
      if (state_i.digit_count < COUNT_MAX) begin
        state_o.digit_count = state_i.digit_count + 3'd1;
      end
    end else begin
      // any other character drops the frame
      state_o.in_frame    = 1'b0;
      state_o.digit_count = '0;
      state_o.value_accum = '0;
    end
  end

endmodule

### hw/rtl/ascii_range_frame_parser_top.sv
// ---------------------------------------------------------------------------
// ascii_range_frame_parser_top
// Parser for 'R' + decimal digits + CR ranging frames, with a frame timeout.
// ---------------------------------------------------------------------------
// The block takes one item (received byte or millisecond tick) every clock
// cycle unless it stalls. Each item is captured in an input register,
// processed in a single pass by the next-state logic, and a completed 3- or
// 4-digit frame lands in the result register, so a CR byte passes the input
// register and then the result register. While the result register holds a
// result that the receiver has not taken, the processing stage holds and the
// input stalls once its register is full, for bytes and ticks alike.
// timeout_ms resets to 500; the user must see that it is written through
// cfg_i only while the block is idle; the block itself does not enforce it.
module ascii_range_frame_parser_top (
  input  logic    clk_i,
  input  logic    rst_ni,
  arfp_item_if.sink     item_i,
  arfp_cfg_if.sink      cfg_i,
  arfp_result_if.source result_o
);
  import arfp_pkg::*;

  // Input register
  logic          in_valid_q;
  logic          kind_q;
  logic [7:0]    byte_q;
  // Parser state and timeout register
  arfp_state_t   state_q, state_d;
  logic [TimeoutW-1:0] timeout_q;
  // Result register
  logic          res_valid_q, res_valid_d;
  arfp_result_t  res_q, res_step;
  logic          emit;
  logic          advance;

  // The processing stage moves when the result slot is free or being drained
  assign advance      = !res_valid_q || result_o.ready;
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  arfp_step u_step (
    .state_i      (state_q),
    .timeout_ms_i (timeout_q),
    .kind_i       (kind_q),
    .rx_byte_i    (byte_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .result_o     (res_step)
  );

  // Input register, control part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  // Input register, payload
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      kind_q <= item_i.kind;
      byte_q <= item_i.rx_byte;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      timeout_q <= cfg_i.timeout_ms;
    end
  end

  // Result register
  always_comb begin
    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      res_q <= res_step;
    end
  end

  assign result_o.valid       = res_valid_q;
  assign result_o.range_value = res_q.range_value;
  assign result_o.digit_total = res_q.digit_total;

  // Checks
`include "ascii_range_frame_parser_top_assert.svh"

  `ARFP_ASSERT_IMPL(a_res_digits, res_valid_q,
                    (res_q.digit_total == COUNT_MIN_OK) || (res_q.digit_total == COUNT_VALUE))
  `ARFP_ASSERT_IMPL(a_idle_clear, !state_q.in_frame,
                    (state_q.digit_count == '0) && (state_q.value_accum == '0))
  `ARFP_ASSERT_NEXT(a_tick_idle, in_valid_q && advance && (kind_q == KIND_TICK)
                    && !state_q.in_frame, $stable(state_q))
  `ARFP_ASSERT_NEXT(a_res_hold, res_valid_q && !result_o.ready,
                    res_valid_q && $stable(res_q))

endmodule

### tb/arfp_frame_checker.sv
// ---------------------------------------------------------------------------
// arfp_frame_checker
// Watches the item, config and result channels of the range frame parser,
// predicts each completed frame and compares it with the block's result.
// ---------------------------------------------------------------------------
module arfp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  arfp_item_if        item_i,
  arfp_cfg_if         cfg_i,
  arfp_result_if      result_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  import arfp_pkg::*;

  arfp_state_t         frame_st;
  logic [TimeoutW-1:0] timeout_cur;
  arfp_result_t        range_q[$];
  int unsigned         mismatch_cnt;
  bit                  frame_done;
  arfp_result_t        frame_res;
  arfp_result_t        range_exp;

  // Frame parser: advances the predicted state by one byte or tick
  task automatic parse_item(input logic kind, input logic [7:0] ch,
                            output bit done, output arfp_result_t res);
    logic [ValueW-1:0] digit;
    done = 1'b0;
    res  = '0;
    digit = ValueW'(ch - CH_ZERO);
    if (kind == KIND_TICK) begin
      // elapsed time only runs inside a frame, saturating
      if (frame_st.in_frame && frame_st.elapsed_ms != ELAPSED_MAX) begin
        frame_st.elapsed_ms = frame_st.elapsed_ms + 1'b1;
      end
    end else if (ch == CH_START) begin
      // 'R' always reopens, even mid-frame
      frame_st.in_frame    = 1'b1;
      frame_st.elapsed_ms  = '0;
      frame_st.digit_count = '0;
      frame_st.value_accum = '0;
    end else if (frame_st.in_frame) begin
      if (frame_st.elapsed_ms > timeout_cur) begin
        // late byte drops the frame
        frame_st.in_frame    = 1'b0;
        frame_st.digit_count = '0;
        frame_st.value_accum = '0;
      end else if (ch == CH_CR) begin
        if (frame_st.digit_count == COUNT_MIN_OK || frame_st.digit_count == COUNT_VALUE) begin
          done            = 1'b1;
          res.range_value = frame_st.value_accum;
          res.digit_total = frame_st.digit_count;
        end
        frame_st.in_frame    = 1'b0;
        frame_st.digit_count = '0;
        frame_st.value_accum = '0;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (frame_st.digit_count < COUNT_VALUE) begin
          frame_st.value_accum = frame_st.value_accum * ValueW'(10) + digit;
        end
        if (frame_st.digit_count < COUNT_MAX) begin
          frame_st.digit_count = frame_st.digit_count + 1'b1;
        end
      end else begin
        // any other character drops the frame
        frame_st.in_frame    = 1'b0;
        frame_st.digit_count = '0;
        frame_st.value_accum = '0;
      end
    end
  endtask

  // Track transfers on all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_st     = '0;
      timeout_cur  = TIMEOUT_RESET;
      mismatch_cnt = 0;
      range_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        timeout_cur = cfg_i.timeout_ms;
      end
      if (item_i.valid && item_i.ready) begin
        parse_item(item_i.kind, item_i.rx_byte, frame_done, frame_res);
        if (frame_done) begin
          range_q.push_back(frame_res);
        end
      end
      if (result_i.valid && result_i.ready) begin
        if (range_q.size() == 0) begin
          mismatch_cnt++;
          $error("range result with no frame pending: range_value %0d digit_total %0d",
                 result_i.range_value, result_i.digit_total);
        end else begin
          range_exp = range_q.pop_front();
          if (result_i.range_value !== range_exp.range_value) begin
            mismatch_cnt++;
            $error("range_value mismatch: expected %0d, actual %0d",
                   range_exp.range_value, result_i.range_value);
          end
          if (result_i.digit_total !== range_exp.digit_total) begin
            mismatch_cnt++;
            $error("digit_total mismatch: expected %0d, actual %0d",
                   range_exp.digit_total, result_i.digit_total);
          end
        end
      end
    end
    mismatch_cnt_o <= mismatch_cnt;
    pending_o      <= range_q.size();
  end

endmodule

### tb/ascii_range_frame_parser_top_tb.sv
// ---------------------------------------------------------------------------
// ascii_range_frame_parser_top_tb
// Drives byte/tick items and timeout settings into the frame parser with
// random gaps and receiver stalls; a checker beside the block predicts and
// compares every completed frame.
// ---------------------------------------------------------------------------
module ascii_range_frame_parser_top_tb;
  import arfp_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxWait     = 12;
  localparam int unsigned HoldCycles  = 250;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned DrainCycles = 8;
  localparam logic [TimeoutW-1:0] TimeoutHigh = 10'd1000;
  localparam logic [TimeoutW-1:0] TimeoutNone = 10'd0;

  logic clk_i;
  logic rst_ni;

  arfp_item_if   item_ch ();
  arfp_cfg_if    cfg_ch ();
  arfp_result_if result_ch ();

  int unsigned         mismatch_cnt;
  int unsigned         pending_cnt;
  int unsigned         cycle_cnt;
  int unsigned         item_cnt;
  int unsigned         range_cnt;
  logic [TimeoutW-1:0] timeout_cur;
  bit                  no_idle;

  ascii_range_frame_parser_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  arfp_frame_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_ch),
    .cfg_i          (cfg_ch),
    .result_i       (result_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("ascii_range_frame_parser_top_tb NOT OK");
      $finish;
    end
  end

  // One item transfer, after a random gap
  task automatic send_item(input logic kind, input logic [7:0] ch);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid   <= 1'b1;
    item_ch.kind    <= kind;
    item_ch.rx_byte <= ch;
    do @(posedge clk_i); while (!item_ch.ready);
    item_cnt++;
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_item(KIND_BYTE, ch);
  endtask

  // rx_byte is don't-care on a tick, so it carries noise
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Wait until every predicted result has been taken, then let the pipe settle
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [TimeoutW-1:0] value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.timeout_ms <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    timeout_cur = value;
  endtask

  // Mostly frame characters, sometimes any byte
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return CH_START;
      1:       return CH_CR;
      2:       return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Ticks scaled to the timeout so that, for timeouts up to 40, both sides of it are reached
  task automatic maybe_ticks();
    int unsigned span;
    span = (timeout_cur < 16) ? timeout_cur / 2 + 1 : 4;
    if ($urandom_range(0, 3) == 0) begin
      send_ticks($urandom_range(1, span));
    end else if (timeout_cur <= 40 && $urandom_range(0, 19) == 0) begin
      send_ticks(timeout_cur + $urandom_range(0, 1));
    end
  endtask

  // One random frame: mostly well formed, else broken or noise
  task automatic send_frame();
    int unsigned digits;
    if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
    if ($urandom_range(0, 9) < 7) begin
      send_byte(CH_START);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: digits = 3;
        4, 5, 6:    digits = 4;
        7:          digits = $urandom_range(0, 2);
        default:    digits = $urandom_range(5, 7);
      endcase
      repeat (digits) begin
        maybe_ticks();
        send_digits(1);
      end
      maybe_ticks();
      if ($urandom_range(0, 9) == 0) send_byte(pick_char());
      send_byte(CH_CR);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 2) == 0) send_ticks(1);
        else send_byte(pick_char());
      end
    end
  endtask

  task automatic run_random(input logic [TimeoutW-1:0] value);
    int unsigned start;
    wait_drained();
    write_timeout(value);
    start = item_cnt;
    while (item_cnt - start < PhaseItems) send_frame();
  endtask

  // Result receiver: random stalls plus long hold-offs to back up the block
  initial begin
    int unsigned stall;
    range_cnt = 0;
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (range_cnt == 25 || range_cnt == 150) stall = HoldCycles;
      else stall = no_idle ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      range_cnt++;
    end
  end

  // Stimulus
  initial begin
    item_cnt    = 0;
    no_idle     = 1'b0;
    timeout_cur = TIMEOUT_RESET;
    item_ch.valid     <= 1'b0;
    item_ch.kind      <= KIND_BYTE;
    item_ch.rx_byte   <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.timeout_ms <= '0;
    rst_ni            <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, at the reset timeout: idle tick and junk, largest value,
    // restart mid-frame with zeros, too many digits, other character
    send_ticks(1);
    send_byte(8'hFF);
    send_byte(CH_START);
    repeat (4) send_byte(8'(CH_ZERO + 9));
    send_byte(CH_CR);
    send_byte(CH_START);
    send_byte(8'(CH_ZERO + 5));
    send_byte(CH_START);
    repeat (3) send_byte(CH_ZERO);
    send_byte(CH_CR);
    send_byte(CH_START);
    send_digits(5);
    send_byte(CH_CR);
    send_byte(CH_START);
    send_digits(1);
    send_byte(8'h00);

    // zero timeout, largest timeouts, then small ones where ticks reach
    // both sides of the limit
    run_random(TimeoutNone);
    run_random(ELAPSED_MAX);
    run_random(TimeoutHigh);
    run_random(10'($urandom_range(1, 40)));
    run_random(10'd3);
    wait_drained();

    if (pending_cnt != 0) $error("%0d range results never arrived", pending_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("ascii_range_frame_parser_top_tb OK");
    end else begin
      $display("ascii_range_frame_parser_top_tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/arfp_pkg.sv
hw/rtl/arfp_item_if.sv
hw/rtl/arfp_result_if.sv
hw/rtl/arfp_cfg_if.sv
hw/rtl/arfp_step.sv
hw/rtl/ascii_range_frame_parser_top.sv
tb/arfp_frame_checker.sv
tb/ascii_range_frame_parser_top_tb.sv
